// ===== rtl/drrtx_pkg.sv =====
// ----------------------------------------------------------------------------
// drrtx_pkg
// Shared types and constants for the descriptor ring receive/transmit handler.
// ----------------------------------------------------------------------------
package drrtx_pkg;

    // Result codes carried in m_tuser
    typedef enum logic [2:0] {
        OC_RX_DELIVERED = 3'd0,
        OC_RX_DROPPED   = 3'd1,
        OC_RX_EMPTY     = 3'd2,
        OC_TX_QUEUED    = 3'd3,
        OC_TX_TOO_LONG  = 3'd4,
        OC_TX_BUSY      = 3'd5
    } outcome_t;

    // Item kind carried in s_tuser
    localparam logic FUNC_RX = 1'b0;
    localparam logic FUNC_TX = 1'b1;

    // Descriptor status word bits
    localparam int OWN_POS    = 31;
    localparam int EOR_POS    = 30;
    localparam int FS_POS     = 29;
    localparam int LS_POS     = 28;
    localparam int RX_ERR_POS = 21;

    localparam int LEN_W      = 14;
    localparam int SLOT_OUT_W = 5;
    localparam int ADDR_W     = 64;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 32;

    localparam logic [LEN_W-1:0] MIN_RX_LEN = 14'd18;
    localparam logic [LEN_W-1:0] CRC_BYTES  = 14'd4;

    // APB register map (64-bit registers at 8-byte steps)
    localparam logic REG_RX_BASE = 1'b0;
    localparam logic REG_TX_BASE = 1'b1;

endpackage

// ===== rtl/descriptor_ring_rx_tx_handler.sv =====
// ----------------------------------------------------------------------------
// descriptor_ring_rx_tx_handler
// Checks receive descriptors and builds transmit descriptors for two
// OWN-bit controlled DMA rings, one item per cycle without m_ stalls.
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit up)                          tuser
//  s_       in         desc_status[31:0], frame_length[45:32]      func
//  m_       out        slot_used, buffer_address, payload_length,  outcome
//                      desc_write, new_desc_word, doorbell,
//                      dropped_total
//  apb      in         rx_buffer_base @0x0, tx_buffer_base @0x8
//
// Items pass an input register, then the result register. Throughput is
// one item per cycle without m_ stalls; ring slots, buffer offsets and the
// drop counter update as an item enters the result register. A stall on m_
// holds it; s_tready is low only in reset or when both stages are full and
// m_ stalls. Synchronous active-low reset clears slots and counters.
// ----------------------------------------------------------------------------
module descriptor_ring_rx_tx_handler #(
    parameter int RX_RING_SLOTS = 32,
    parameter int TX_RING_SLOTS = 32,
    parameter int BUFFER_BYTES  = 2048
) (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // desc_status[31:0], frame_length[45:32], zero pad
    input  logic         s_tuser,   // func

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // slot_used[4:0], buffer_address[68:5],
                                    // payload_length[82:69], desc_write[83],
                                    // new_desc_word[115:84], doorbell[116],
                                    // dropped_total[148:117], zero pad
    output logic [2:0]   m_tuser,   // outcome

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import drrtx_pkg::*;

    localparam int RX_SLOT_W = $clog2(RX_RING_SLOTS);
    localparam int TX_SLOT_W = $clog2(TX_RING_SLOTS);
    localparam int RX_OFF_W  = $clog2(RX_RING_SLOTS * BUFFER_BYTES);
    localparam int TX_OFF_W  = $clog2(TX_RING_SLOTS * BUFFER_BYTES);

    localparam logic [RX_SLOT_W-1:0] RX_LAST  = RX_SLOT_W'(RX_RING_SLOTS - 1);
    localparam logic [TX_SLOT_W-1:0] TX_LAST  = TX_SLOT_W'(TX_RING_SLOTS - 1);
    localparam logic [RX_OFF_W-1:0]  RX_STEP  = RX_OFF_W'(BUFFER_BYTES);
    localparam logic [TX_OFF_W-1:0]  TX_STEP  = TX_OFF_W'(BUFFER_BYTES);
    localparam logic [LEN_W-1:0]     BUF_LEN  = LEN_W'(BUFFER_BYTES);

    // configuration
    logic [ADDR_W-1:0] rx_base_reg;
    logic [ADDR_W-1:0] tx_base_reg;
    logic              cfg_write;

    // ring state; offsets track slot * BUFFER_BYTES
    logic [RX_SLOT_W-1:0] rx_slot_reg;
    logic [TX_SLOT_W-1:0] tx_slot_reg;
    logic [RX_OFF_W-1:0]  rx_off_reg;
    logic [TX_OFF_W-1:0]  tx_off_reg;
    logic [COUNT_W-1:0]   drop_count_reg;

    // input stage
    logic              in_valid_reg;
    logic              in_func_reg;
    logic [WORD_W-1:0] in_desc_reg;
    logic [LEN_W-1:0]  in_flen_reg;

    // result stage
    logic              out_valid_reg;
    logic [2:0]        out_user_reg;
    logic [151:0]      out_data_reg;

    logic advance;

    // item results
    outcome_t          outcome;
    logic [SLOT_OUT_W-1:0] slot_used;
    logic [ADDR_W-1:0] buf_addr;
    logic [LEN_W-1:0]  pay_len;
    logic              desc_wr;
    logic [WORD_W-1:0] new_word;
    logic              bell;
    logic              rx_adv;
    logic              tx_adv;
    logic              drop;
    logic [LEN_W-1:0]  rx_len;
    logic              rx_good;

    logic [RX_SLOT_W-1:0] rx_slot_next;
    logic [TX_SLOT_W-1:0] tx_slot_next;
    logic [RX_OFF_W-1:0]  rx_off_next;
    logic [TX_OFF_W-1:0]  tx_off_next;
    logic [COUNT_W-1:0]   drop_count_next;

    // ------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[3] == REG_TX_BASE) ? tx_base_reg : rx_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_base_reg <= '0;
            tx_base_reg <= '0;
        end else if (cfg_write) begin
            if (paddr[3] == REG_RX_BASE) begin
                rx_base_reg <= pwdata;
            end else begin
                tx_base_reg <= pwdata;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    // no item is taken while reset is held
    assign s_tready = aresetn & (~in_valid_reg | advance);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_func_reg <= s_tuser;
            in_desc_reg <= s_tdata[31:0];
            in_flen_reg <= s_tdata[45:32];
        end
    end

    // ------------------------------------------------------------------
    // Descriptor decision
    // ------------------------------------------------------------------
    assign rx_len  = in_desc_reg[LEN_W-1:0];
    assign rx_good = in_desc_reg[FS_POS] & in_desc_reg[LS_POS] &
                     (rx_len > MIN_RX_LEN) & ~in_desc_reg[RX_ERR_POS];

    always_comb begin
        outcome  = OC_RX_EMPTY;
        slot_used = SLOT_OUT_W'(rx_slot_reg);
        buf_addr = '0;
        pay_len  = '0;
        desc_wr  = 1'b0;
        new_word = '0;
        bell     = 1'b0;
        rx_adv   = 1'b0;
        tx_adv   = 1'b0;
        drop     = 1'b0;
        if (in_func_reg == FUNC_RX) begin
            if (!in_desc_reg[OWN_POS]) begin
                rx_adv  = 1'b1;
                desc_wr = 1'b1;
                new_word[OWN_POS]     = 1'b1;
                new_word[EOR_POS]     = (rx_slot_reg == RX_LAST);
                new_word[LEN_W-1:0]   = BUF_LEN;
                if (rx_good) begin
                    outcome  = OC_RX_DELIVERED;
                    buf_addr = rx_base_reg + ADDR_W'(rx_off_reg);
                    pay_len  = rx_len - CRC_BYTES;
                end else begin
                    outcome = OC_RX_DROPPED;
                    drop    = 1'b1;
                end
            end
        end else begin
            slot_used = SLOT_OUT_W'(tx_slot_reg);
            if (in_flen_reg > BUF_LEN) begin
                outcome = OC_TX_TOO_LONG;
            end else if (in_desc_reg[OWN_POS]) begin
                outcome = OC_TX_BUSY;
            end else begin
                outcome  = OC_TX_QUEUED;
                tx_adv   = 1'b1;
                buf_addr = tx_base_reg + ADDR_W'(tx_off_reg);
                pay_len  = in_flen_reg;
                desc_wr  = 1'b1;
                bell     = 1'b1;
                new_word[OWN_POS]   = 1'b1;
                new_word[FS_POS]    = 1'b1;
                new_word[LS_POS]    = 1'b1;
                new_word[EOR_POS]   = (tx_slot_reg == TX_LAST);
                new_word[LEN_W-1:0] = in_flen_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Ring state
    // ------------------------------------------------------------------
    always_comb begin
        rx_slot_next    = rx_slot_reg;
        rx_off_next     = rx_off_reg;
        tx_slot_next    = tx_slot_reg;
        tx_off_next     = tx_off_reg;
        drop_count_next = drop_count_reg + COUNT_W'(drop);
        if (rx_adv) begin
            if (rx_slot_reg == RX_LAST) begin
                rx_slot_next = '0;
                rx_off_next  = '0;
            end else begin
                rx_slot_next = rx_slot_reg + RX_SLOT_W'(1);
                rx_off_next  = rx_off_reg + RX_STEP;
            end
        end
        if (tx_adv) begin
            if (tx_slot_reg == TX_LAST) begin
                tx_slot_next = '0;
                tx_off_next  = '0;
            end else begin
                tx_slot_next = tx_slot_reg + TX_SLOT_W'(1);
                tx_off_next  = tx_off_reg + TX_STEP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_slot_reg    <= '0;
            rx_off_reg     <= '0;
            tx_slot_reg    <= '0;
            tx_off_reg     <= '0;
            drop_count_reg <= '0;
        end else if (advance) begin
            rx_slot_reg    <= rx_slot_next;
            rx_off_reg     <= rx_off_next;
            tx_slot_reg    <= tx_slot_next;
            tx_off_reg     <= tx_off_next;
            drop_count_reg <= drop_count_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_user_reg <= outcome;
            out_data_reg <= {3'b000, drop_count_next, bell, new_word, desc_wr,
                             pay_len, buf_addr, slot_used};
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_drop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && drop_count_reg != $past(drop_count_reg)) |->
        drop_count_reg == $past(drop_count_reg) + COUNT_W'(1))
        else $error("drop counter moved by more than one");

    a_rx_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(rx_off_reg) == 32'(rx_slot_reg) * 32'(BUFFER_BYTES))
        else $error("rx buffer offset out of step with rx slot");

    a_bell_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[116]) |-> m_tuser == OC_TX_QUEUED)
        else $error("doorbell without a queued tx item");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !in_valid_reg) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule
